>>> rtl/stp_pkg.sv
// stp_pkg: shared types and constants for the stepper trapezoid profile executor
// command, result and queue entry structs, mode and register codes
// no dependencies
package stp_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        move_direction;
        logic [30:0] accel_steps;
        logic [30:0] cruise_steps;
        logic [30:0] decel_steps;
        logic [23:0] start_speed;
        logic [23:0] cruise_speed;
        logic [23:0] end_speed;
        logic [31:0] accel_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               direction_pin;
        logic [15:0]        prescaler;
        logic [15:0]        period;
        logic [14:0]        compare_value;
        logic               running;
        logic [3:0]         queue_count;
        logic               accepted;
    } result_t;

    typedef struct packed {
        logic        dir;
        logic [30:0] accel_left;
        logic [30:0] cruise_left;
        logic [30:0] decel_left;
        logic [23:0] start_spd;
        logic [23:0] cruise_spd;
        logic [23:0] end_spd;
        logic [31:0] accel;
    } node_t;

    localparam logic [1:0] MODE_QUEUE = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_RUN   = 2'd3;

    localparam logic [1:0] CFG_JERK    = 2'd0;
    localparam logic [1:0] CFG_REVERSE = 2'd1;
    localparam logic [1:0] CFG_CLOCK   = 2'd2;

    localparam logic [30:0] ENDLESS     = 31'h7FFF_FFFF;
    localparam logic [21:0] F_MAX       = 22'd3000000;
    localparam logic [28:0] TICK_RESET  = 29'd3000000;
    localparam logic [23:0] JERK_RESET  = 24'd256;
    localparam logic [28:0] CLOCK_RESET = 29'd96000000;

    localparam int DIV_W     = 40;
    localparam int DSR_W     = 24;
    localparam int DIV_CNT_W = 6;

endpackage

>>> rtl/stepper_trapezoid_profile_executor_top.sv
// stepper_trapezoid_profile_executor_top: node queue, step sequencer, speed ramp and
// step timer setup around one bit-serial divider
// depends on stp_pkg and stp_ram
//
// One command is taken when start is high and busy is low; its result is shown for
// exactly one cycle with done high and cannot be held off. Every speed change runs
// the timer setup: up to three passes of the shared restoring divider (divider, tick
// rate, period). A tick in a ramp phase adds one divider pass for the speed
// increment, and a tick that finishes a node and activates the next runs the timer
// setup again.
module stepper_trapezoid_profile_executor_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  stp_pkg::cmd_t   cmd,
    output logic            done,
    output stp_pkg::result_t result,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_addr,
    input  logic [28:0]     cfg_wdata
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $bits(stp_pkg::node_t);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_RAMP   = 4'd2;
    localparam logic [3:0] S_TMR    = 4'd3;
    localparam logic [3:0] S_DIVA   = 4'd4;
    localparam logic [3:0] S_DIVB   = 4'd5;
    localparam logic [3:0] S_DIVC   = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_ACT_RD = 4'd8;
    localparam logic [3:0] S_ACT    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [IW-1:0]     head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [23:0]       speed_reg, speed_next, target_reg, target_next;
    logic [31:0]       pos_reg, pos_next;
    logic              run_reg, run_next, dir_reg, dir_next;
    logic [15:0]       pre_reg, pre_next, per_reg, per_next;
    logic [28:0]       tick_reg, tick_next;
    logic              acc_reg, acc_next, pop_reg, pop_next;
    logic [23:0]       jerk_reg;
    logic              rev_reg;
    logic [28:0]       clkhz_reg;
    stp_pkg::node_t    nd_reg, nd_next;

    logic [stp_pkg::DIV_W-1:0]     dvd_reg, dvd_next, quo_reg, quo_next;
    logic [stp_pkg::DSR_W:0]       rem_reg, rem_next;
    logic [stp_pkg::DSR_W-1:0]     dsr_reg, dsr_next;
    logic [stp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic                      div_go;
    logic [stp_pkg::DIV_W-1:0] div_dvd;
    logic [stp_pkg::DSR_W-1:0] div_dsr;
    logic [stp_pkg::DSR_W:0]   rem_sh;
    logic                      rem_ge;

    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    stp_pkg::node_t ram_wdata, ram_rdata;

    logic [39:0] prod;
    logic [31:0] f_raw;
    logic [21:0] f_val;
    logic [16:0] div_val, div_m1;
    logic [23:0] rdiv, diff;
    logic [30:0] a_new, c_new, d_new;
    logic        ramp_go, node_end;
    logic [IW-1:0] head_inc, tail_inc;
    logic        full;

    stp_ram #(
        .WIDTH (NW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jerk_reg  <= stp_pkg::JERK_RESET;
            rev_reg   <= 1'b0;
            clkhz_reg <= stp_pkg::CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                stp_pkg::CFG_JERK:    jerk_reg  <= cfg_wdata[23:0];
                stp_pkg::CFG_REVERSE: rev_reg   <= cfg_wdata[0];
                stp_pkg::CFG_CLOCK:   clkhz_reg <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    assign head_inc = (head_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign full     = (count_reg == CW'(QUEUE_DEPTH));

    // divider datapath, one quotient bit per cycle
    assign rem_sh = {rem_reg[stp_pkg::DSR_W-1:0], dvd_reg[stp_pkg::DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, dsr_reg});

    // timer helpers
    assign prod  = {speed_reg, 16'd0} - {16'd0, speed_reg};
    assign f_raw = prod[39:8];
    always_comb
    begin
        if (f_raw > {10'd0, stp_pkg::F_MAX})
        begin
            f_val = stp_pkg::F_MAX;
        end
        else if (f_raw == 32'd0)
        begin
            f_val = 22'd1;
        end
        else
        begin
            f_val = f_raw[21:0];
        end
        if (quo_reg > 40'd65536)
        begin
            div_val = 17'd65536;
        end
        else if (quo_reg == 40'd0)
        begin
            div_val = 17'd1;
        end
        else
        begin
            div_val = quo_reg[16:0];
        end
        div_m1 = div_val - 17'd1;
    end

    assign rdiv = (speed_reg < jerk_reg) ? jerk_reg : speed_reg;
    assign diff = (speed_reg < target_reg) ? target_reg - speed_reg : speed_reg - target_reg;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        speed_next  = speed_reg;
        target_next = target_reg;
        pos_next    = pos_reg;
        run_next    = run_reg;
        dir_next    = dir_reg;
        pre_next    = pre_reg;
        per_next    = per_reg;
        tick_next   = tick_reg;
        acc_next    = acc_reg;
        pop_next    = pop_reg;
        nd_next     = nd_reg;
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        ram_wdata   = nd_reg;
        div_go      = 1'b0;
        div_dvd     = '0;
        div_dsr     = '0;
        a_new       = ram_rdata.accel_left;
        c_new       = ram_rdata.cruise_left;
        d_new       = ram_rdata.decel_left;
        ramp_go     = 1'b0;
        node_end    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    acc_next   = 1'b1;
                    state_next = S_OUT;
                    unique case (cmd.mode)
                        stp_pkg::MODE_QUEUE:
                        begin
                            if (full)
                            begin
                                acc_next = 1'b0;
                            end
                            else
                            begin
                                ram_we                = 1'b1;
                                ram_waddr             = tail_reg;
                                ram_wdata.dir         = cmd.move_direction;
                                ram_wdata.accel_left  = cmd.accel_steps;
                                ram_wdata.cruise_left = cmd.cruise_steps;
                                ram_wdata.decel_left  = cmd.decel_steps;
                                ram_wdata.start_spd   = cmd.start_speed;
                                ram_wdata.cruise_spd  = cmd.cruise_speed;
                                ram_wdata.end_spd     = cmd.end_speed;
                                ram_wdata.accel       = cmd.accel_rate;
                                tail_next             = tail_inc;
                                count_next            = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    dir_next   = cmd.move_direction ^ rev_reg;
                                    speed_next = (cmd.accel_steps != '0) ?
                                                 cmd.start_speed : cmd.cruise_speed;
                                    pop_next   = 1'b0;
                                    state_next = S_TMR;
                                end
                            end
                        end
                        stp_pkg::MODE_TICK:
                        begin
                            if (run_reg)
                            begin
                                pos_next = dir_reg ? pos_reg + 32'd1 : pos_reg - 32'd1;
                                if (count_reg != '0)
                                begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        stp_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                        stp_pkg::MODE_RUN:
                        begin
                            if (count_reg != '0)
                            begin
                                run_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD:
            begin
                if (ram_rdata.accel_left != '0)
                begin
                    a_new       = ram_rdata.accel_left - 31'd1;
                    target_next = ram_rdata.cruise_spd;
                    ramp_go     = 1'b1;
                end
                else if (ram_rdata.cruise_left != '0)
                begin
                    if (ram_rdata.cruise_left != stp_pkg::ENDLESS)
                    begin
                        c_new = ram_rdata.cruise_left - 31'd1;
                    end
                end
                else if (ram_rdata.decel_left != '0)
                begin
                    d_new       = ram_rdata.decel_left - 31'd1;
                    target_next = ram_rdata.end_spd;
                    ramp_go     = 1'b1;
                end
                node_end            = (a_new == '0) && (c_new == '0) && (d_new == '0);
                nd_next             = ram_rdata;
                nd_next.accel_left  = a_new;
                nd_next.cruise_left = c_new;
                nd_next.decel_left  = d_new;
                ram_we              = 1'b1;
                ram_waddr           = head_reg;
                ram_wdata           = nd_next;
                pop_next            = node_end;
                if (ramp_go)
                begin
                    state_next = S_RAMP;
                    if (rdiv == '0)
                    begin
                        speed_next = target_next;
                        state_next = S_TMR;
                    end
                    else
                    begin
                        div_go  = 1'b1;
                        div_dvd = {ram_rdata.accel, 8'd0};
                        div_dsr = rdiv;
                    end
                end
                else
                begin
                    state_next = node_end ? S_POP : S_OUT;
                end
            end
            S_RAMP:
            begin
                if (cnt_reg == '0)
                begin
                    if (quo_reg >= {16'd0, diff})
                    begin
                        speed_next = target_reg;
                    end
                    else if (speed_reg < target_reg)
                    begin
                        speed_next = speed_reg + quo_reg[23:0];
                    end
                    else
                    begin
                        speed_next = speed_reg - quo_reg[23:0];
                    end
                    state_next = S_TMR;
                end
            end
            S_TMR:
            begin
                if (speed_reg == '0)
                begin
                    per_next   = '0;
                    state_next = pop_reg ? S_POP : S_OUT;
                end
                else
                begin
                    div_go     = 1'b1;
                    div_dvd    = {11'd0, clkhz_reg} + {18'd0, f_val} - 40'd1;
                    div_dsr    = {2'd0, f_val};
                    state_next = S_DIVA;
                end
            end
            S_DIVA:
            begin
                if (cnt_reg == '0)
                begin
                    div_go = 1'b1;
                    if (div_m1[15:0] != pre_reg)
                    begin
                        pre_next   = div_m1[15:0];
                        div_dvd    = {11'd0, clkhz_reg};
                        div_dsr    = {7'd0, div_val};
                        state_next = S_DIVB;
                    end
                    else
                    begin
                        div_dvd    = {3'd0, tick_reg, 8'd0};
                        div_dsr    = speed_reg;
                        state_next = S_DIVC;
                    end
                end
            end
            S_DIVB:
            begin
                if (cnt_reg == '0)
                begin
                    tick_next  = quo_reg[28:0];
                    div_go     = 1'b1;
                    div_dvd    = {3'd0, quo_reg[28:0], 8'd0};
                    div_dsr    = speed_reg;
                    state_next = S_DIVC;
                end
            end
            S_DIVC:
            begin
                if (cnt_reg == '0)
                begin
                    per_next   = (quo_reg > 40'd65535) ? 16'hFFFF : quo_reg[15:0];
                    state_next = pop_reg ? S_POP : S_OUT;
                end
            end
            S_POP:
            begin
                pop_next   = 1'b0;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                if (count_reg != CW'(1))
                begin
                    state_next = S_ACT_RD;
                end
                else
                begin
                    run_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_ACT_RD:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                dir_next   = ram_rdata.dir ^ rev_reg;
                speed_next = (ram_rdata.accel_left != '0) ?
                             ram_rdata.start_spd : ram_rdata.cruise_spd;
                state_next = S_TMR;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (div_go)
        begin
            dvd_next = div_dvd;
            dsr_next = div_dsr;
            quo_next = '0;
            rem_next = '0;
            cnt_next = stp_pkg::DIV_CNT_W'(stp_pkg::DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next = {dvd_reg[stp_pkg::DIV_W-2:0], 1'b0};
            quo_next = {quo_reg[stp_pkg::DIV_W-2:0], rem_ge};
            rem_next = rem_ge ? rem_sh - {1'b0, dsr_reg} : rem_sh;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            speed_reg <= '0;
            pos_reg   <= '0;
            run_reg   <= 1'b0;
            dir_reg   <= 1'b0;
            pre_reg   <= '0;
            per_reg   <= '0;
            tick_reg  <= stp_pkg::TICK_RESET;
            acc_reg   <= 1'b1;
            pop_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            speed_reg <= speed_next;
            pos_reg   <= pos_next;
            run_reg   <= run_next;
            dir_reg   <= dir_next;
            pre_reg   <= pre_next;
            per_reg   <= per_next;
            tick_reg  <= tick_next;
            acc_reg   <= acc_next;
            pop_reg   <= pop_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        nd_reg     <= nd_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
    end

    assign busy                 = (state_reg != S_IDLE);
    assign done                 = (state_reg == S_OUT);
    assign result.position      = pos_reg;
    assign result.direction_pin = dir_reg;
    assign result.prescaler     = pre_reg;
    assign result.period        = per_reg;
    assign result.compare_value = per_reg[15:1];
    assign result.running       = run_reg;
    assign result.queue_count   = 4'(count_reg);
    assign result.accepted      = acc_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !acc_reg) |-> full)
        else $error("command refused while queue had room");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer taken but block not busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown for more than one cycle");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (state_reg == S_RAMP || state_reg == S_DIVA ||
                             state_reg == S_DIVB || state_reg == S_DIVC))
        else $error("divider running outside a wait state");

endmodule

>>> rtl/stp_ram.sv
// stp_ram: generic single write, single read memory with registered read data
// used for the motion node queue
// no dependencies
module stp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
